// ===== src/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// types, action codes and status codes shared by the task scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

    // widest task index the design supports (64 tasks)
    localparam int IDX_W   = 6;
    localparam int TOTAL_W = 7;

    localparam logic [3:0] ACT_CREATE      = 4'd0;
    localparam logic [3:0] ACT_DELAY       = 4'd1;
    localparam logic [3:0] ACT_WAIT        = 4'd2;
    localparam logic [3:0] ACT_LOCK        = 4'd3;
    localparam logic [3:0] ACT_POST        = 4'd4;
    localparam logic [3:0] ACT_UNLOCK      = 4'd5;
    localparam logic [3:0] ACT_TICK        = 4'd6;
    localparam logic [3:0] ACT_INIT_LOCK   = 4'd7;
    localparam logic [3:0] ACT_SET_TICKS   = 4'd8;
    localparam logic [3:0] ACT_RUN         = 4'd9;
    localparam logic [3:0] ACT_WAIT_FINISH = 4'd10;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_TAKEN   = 3'd1;
    localparam logic [2:0] ST_WAITING = 3'd2;
    localparam logic [2:0] ST_POSTED  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_NONE    = 3'd5;
    localparam logic [2:0] ST_MISUSE  = 3'd6;
    localparam logic [2:0] ST_FULL    = 3'd7;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_DELAY   = 2'd1;
    localparam logic [1:0] EV_TIMED   = 2'd2;
    localparam logic [1:0] EV_ENDLESS = 2'd3;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  task_priority;
        logic [3:0]  lock_id;
        logic [31:0] amount;
        logic [7:0]  lock_count;
    } pts_in_t;

    typedef struct packed {
        logic [3:0]  next_task;
        logic        switch_needed;
        logic [2:0]  status;
        logic [31:0] ticks_now;
    } pts_out_t;

    // token handed along the cell chain
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [7:0]       prio;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
    } token_t;

    // broadcast write into one cell
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             prio_en;
        logic             wake_en;
        logic [7:0]       prio;
        logic [1:0]       kind;
        logic [3:0]       lock;
        logic [31:0]      wake;
    } cell_wr_t;

    // values every cell sees during a scan
    typedef struct packed {
        logic [31:0]        tick;
        logic [TOTAL_W-1:0] total;
        logic [3:0]         lock;
    } scan_ctx_t;

endpackage

// ===== src/pts_cell.sv =====
// ----------------------------------------------------------------------------
// pts_cell
// one task entry: holds priority, event and wake time, and folds itself into
// the scan token passed on to the next cell
// ----------------------------------------------------------------------------
module pts_cell #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pts_pkg::cell_wr_t  wr,
    input  pts_pkg::scan_ctx_t ctx,
    input  pts_pkg::token_t    tok_in,
    output pts_pkg::token_t    tok_out,
    output logic [1:0]         kind
);

    logic [7:0]      prio_reg;
    logic [1:0]      kind_reg;
    logic [3:0]      lock_reg;
    logic [31:0]     wake_reg;
    pts_pkg::token_t tok_reg;
    pts_pkg::token_t tok_next;
    logic            sel;
    logic            in_use;
    logic            ready;
    logic            waiter;

    assign sel = wr.en && (wr.idx == pts_pkg::IDX_W'(IDX));

    always_ff @(posedge clk)
    begin
        if (sel && wr.prio_en)
        begin
            prio_reg <= wr.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= pts_pkg::EV_NONE;
            lock_reg <= '0;
            wake_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (sel)
            begin
                kind_reg <= wr.kind;
                lock_reg <= wr.lock;
                if (wr.wake_en)
                begin
                    wake_reg <= wr.wake;
                end
            end
        end
    end

    always_comb
    begin
        in_use = pts_pkg::TOTAL_W'(IDX) < ctx.total;
        if (kind_reg == pts_pkg::EV_NONE)
        begin
            ready = 1'b1;
        end
        else if (lock_reg == 4'd0 || kind_reg == pts_pkg::EV_TIMED)
        begin
            ready = ctx.tick >= wake_reg;
        end
        else
        begin
            ready = 1'b0;
        end
        waiter = (lock_reg == ctx.lock)
              && (kind_reg == pts_pkg::EV_TIMED || kind_reg == pts_pkg::EV_ENDLESS);

        tok_next = tok_in;
        if (in_use && ready && (!tok_in.found || prio_reg < tok_in.prio))
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = pts_pkg::IDX_W'(IDX);
            tok_next.prio  = prio_reg;
        end
        // first waiter on the lock wins
        if (in_use && waiter && !tok_in.hit)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = pts_pkg::IDX_W'(IDX);
        end
    end

    assign tok_out = tok_reg;
    assign kind    = kind_reg;

endmodule

// ===== src/priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler
// task scheduler with counting semaphores built on a chain of task cells
// ----------------------------------------------------------------------------
// One item at a time. Each task sits in a cell of a chain; a scan token walks
// the chain one cell per clock, so a reschedule or a waiter search walks every
// cell. Actions without a scan pass through the execute and output states; those
// with a reschedule add a scan and a schedule step; a post that wakes a waiter
// while running scans once for the waiter and once more to reschedule. The
// next item is accepted once the current one has reached the output register.
module priority_task_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int MAX_LOCKS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pts_pkg::pts_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output pts_pkg::pts_out_t out_data
);

    localparam int TW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int LW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCANP = 3'd2;
    localparam logic [2:0] S_POST  = 3'd3;
    localparam logic [2:0] S_SCANS = 3'd4;
    localparam logic [2:0] S_SCHED = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [TW-1:0]     cnt_reg, cnt_next;
    pts_pkg::pts_in_t  in_reg;
    logic [31:0]       tick_reg, tick_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [TW-1:0]     cur_reg, cur_next;
    logic              run_reg, run_next;
    logic [7:0]        sem_reg [MAX_LOCKS];
    logic              sem_we;
    logic [7:0]        sem_wd;
    logic [2:0]        status_reg, status_next;
    logic              sw_reg, sw_next;
    logic              out_valid_reg;
    pts_pkg::pts_out_t out_reg;

    pts_pkg::cell_wr_t  wr;
    pts_pkg::scan_ctx_t ctx;
    pts_pkg::token_t    tok [MAX_TASKS+1];
    logic [1:0]         cell_kind [MAX_TASKS];

    logic [31:0]   lk32;
    logic [LW-1:0] lk_i;
    logic          lock_bad;
    logic [7:0]    sem_cur;
    logic [31:0]   wake_sum;
    logic [31:0]   cur32;
    logic          accept;
    logic          scan_last;
    logic [TW-1:0] best;

    assign tok[0] = '0;

    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_cell
        pts_cell #(.IDX(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .ctx     (ctx),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .kind    (cell_kind[g])
        );
    end

    assign ctx.tick  = tick_reg;
    assign ctx.total = pts_pkg::TOTAL_W'(total_reg);
    assign ctx.lock  = in_reg.lock_id;

    assign in_stall  = state_reg != S_IDLE;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign lk32      = 32'(in_reg.lock_id);
    assign lk_i      = lk32[LW-1:0];
    assign lock_bad  = lk32 >= MAX_LOCKS;
    assign sem_cur   = sem_reg[lk_i];
    assign wake_sum  = tick_reg + in_reg.amount;
    assign cur32     = 32'(cur_reg);
    assign scan_last = cnt_reg == TW'(MAX_TASKS - 1);
    assign best      = tok[MAX_TASKS].idx[TW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = '0;
        tick_next   = tick_reg;
        total_next  = total_reg;
        cur_next    = cur_reg;
        run_next    = run_reg;
        status_next = status_reg;
        sw_next     = sw_reg;
        sem_we      = 1'b0;
        sem_wd      = sem_cur;
        wr          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_EXEC;
                    status_next = pts_pkg::ST_DONE;
                    sw_next     = 1'b0;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                case (in_reg.action)
                    pts_pkg::ACT_CREATE:
                    begin
                        if (32'(total_reg) >= MAX_TASKS)
                        begin
                            status_next = pts_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr.en      = 1'b1;
                            wr.idx     = pts_pkg::IDX_W'(total_reg);
                            wr.prio_en = 1'b1;
                            wr.wake_en = 1'b1;
                            wr.prio    = in_reg.task_priority;
                            total_next = total_reg + CW'(1);
                            state_next = run_reg ? S_SCANS : S_OUT;
                        end
                    end
                    pts_pkg::ACT_DELAY:
                    begin
                        if (!run_reg)
                        begin
                            status_next = pts_pkg::ST_MISUSE;
                        end
                        else
                        begin
                            wr.en      = 1'b1;
                            wr.idx     = pts_pkg::IDX_W'(cur_reg);
                            wr.wake_en = 1'b1;
                            wr.kind    = pts_pkg::EV_DELAY;
                            wr.wake    = wake_sum;
                            state_next = S_SCANS;
                        end
                    end
                    pts_pkg::ACT_WAIT, pts_pkg::ACT_LOCK:
                    begin
                        if (lock_bad
                            || (in_reg.action == pts_pkg::ACT_LOCK && sem_cur > 8'd1))
                        begin
                            status_next = pts_pkg::ST_MISUSE;
                        end
                        else if (sem_cur != 8'd0)
                        begin
                            sem_we      = 1'b1;
                            sem_wd      = sem_cur - 8'd1;
                            status_next = pts_pkg::ST_TAKEN;
                        end
                        else if (!run_reg)
                        begin
                            status_next = pts_pkg::ST_MISUSE;
                        end
                        else
                        begin
                            wr.en       = 1'b1;
                            wr.idx      = pts_pkg::IDX_W'(cur_reg);
                            wr.wake_en  = 1'b1;
                            wr.kind     = (in_reg.amount != 32'd0) ? pts_pkg::EV_TIMED
                                                                   : pts_pkg::EV_ENDLESS;
                            wr.lock     = in_reg.lock_id;
                            wr.wake     = wake_sum;
                            status_next = pts_pkg::ST_WAITING;
                            state_next  = S_SCANS;
                        end
                    end
                    pts_pkg::ACT_POST, pts_pkg::ACT_UNLOCK:
                    begin
                        if (lock_bad
                            || (in_reg.action == pts_pkg::ACT_UNLOCK && sem_cur != 8'd0))
                        begin
                            status_next = pts_pkg::ST_MISUSE;
                        end
                        else
                        begin
                            state_next = S_SCANP;
                        end
                    end
                    pts_pkg::ACT_TICK:
                    begin
                        tick_next  = tick_reg + 32'd1;
                        state_next = run_reg ? S_SCANS : S_OUT;
                    end
                    pts_pkg::ACT_INIT_LOCK:
                    begin
                        if (lock_bad)
                        begin
                            status_next = pts_pkg::ST_MISUSE;
                        end
                        else
                        begin
                            sem_we = 1'b1;
                            sem_wd = in_reg.lock_count;
                        end
                    end
                    pts_pkg::ACT_SET_TICKS:
                    begin
                        tick_next = in_reg.amount;
                    end
                    pts_pkg::ACT_RUN:
                    begin
                        run_next   = 1'b1;
                        state_next = S_SCANS;
                    end
                    pts_pkg::ACT_WAIT_FINISH:
                    begin
                        if (!run_reg)
                        begin
                            status_next = pts_pkg::ST_MISUSE;
                        end
                        else if (cell_kind[cur_reg] == pts_pkg::EV_NONE)
                        begin
                            status_next = pts_pkg::ST_TAKEN;
                        end
                        else
                        begin
                            // clear the event, wake time stays
                            wr.en       = 1'b1;
                            wr.idx      = pts_pkg::IDX_W'(cur_reg);
                            status_next = pts_pkg::ST_TIMEOUT;
                        end
                    end
                    default:
                    begin
                        status_next = pts_pkg::ST_MISUSE;
                    end
                endcase
            end
            S_SCANP:
            begin
                cnt_next = cnt_reg + TW'(1);
                if (scan_last)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (tok[MAX_TASKS].hit)
                begin
                    wr.en       = 1'b1;
                    wr.idx      = tok[MAX_TASKS].hit_idx;
                    wr.wake_en  = 1'b1;
                    status_next = pts_pkg::ST_POSTED;
                    state_next  = run_reg ? S_SCANS : S_OUT;
                end
                else
                begin
                    // count saturates at 255
                    if (sem_cur != 8'hFF)
                    begin
                        sem_we = 1'b1;
                        sem_wd = sem_cur + 8'd1;
                    end
                    state_next = S_OUT;
                end
            end
            S_SCANS:
            begin
                cnt_next = cnt_reg + TW'(1);
                if (scan_last)
                begin
                    state_next = S_SCHED;
                end
            end
            S_SCHED:
            begin
                if (!tok[MAX_TASKS].found)
                begin
                    status_next = pts_pkg::ST_NONE;
                end
                else
                begin
                    sw_next  = best != cur_reg;
                    cur_next = best;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            out_reg.next_task     <= cur32[3:0];
            out_reg.switch_needed <= sw_reg;
            out_reg.status        <= status_reg;
            out_reg.ticks_now     <= tick_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            total_reg     <= '0;
            cur_reg       <= '0;
            run_reg       <= 1'b0;
            status_reg    <= pts_pkg::ST_DONE;
            sw_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_LOCKS; i++)
            begin
                sem_reg[i] <= (i == 0) ? 8'd1 : 8'd0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            tick_reg   <= tick_next;
            total_reg  <= total_next;
            cur_reg    <= cur_next;
            run_reg    <= run_next;
            status_reg <= status_next;
            sw_reg     <= sw_next;
            if (sem_we)
            begin
                sem_reg[lk_i] <= sem_wd;
            end
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== tb/sv/priority_task_scheduler_checker.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler_checker
// watches both channels, predicts each result of the scheduler and compares
// ----------------------------------------------------------------------------
// Every accepted input item is run through a local copy of the task table,
// semaphore counts and tick counter. The expected result is queued and each
// accepted output item is compared field by field with the oldest entry.
module priority_task_scheduler_checker #(
    parameter int MAX_TASKS = 16,
    parameter int MAX_LOCKS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  pts_pkg::pts_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  pts_pkg::pts_out_t out_data,
    output int                errors,
    output int                pending
);

    logic [7:0]  prio_tbl  [MAX_TASKS];
    logic [1:0]  kind_tbl  [MAX_TASKS];
    logic [3:0]  lock_tbl  [MAX_TASKS];
    logic [31:0] wake_tbl  [MAX_TASKS];
    logic [7:0]  sem_cnt   [MAX_LOCKS];
    int          n_tasks;
    int          cur_task;
    logic        running;
    logic [31:0] ticks;

    pts_pkg::pts_out_t expected_results[$];

    assign pending = expected_results.size();

    function automatic logic is_ready(int i);
        if (kind_tbl[i] == pts_pkg::EV_NONE)
            return 1'b1;
        if (lock_tbl[i] == 4'd0 || kind_tbl[i] == pts_pkg::EV_TIMED)
            return ticks >= wake_tbl[i];
        return 1'b0;
    endfunction

    function automatic void reschedule(inout logic [2:0] st, inout logic sw);
        int  best;
        logic found;
        best  = 0;
        found = 1'b0;
        if (!running)
            return;
        for (int i = 0; i < n_tasks; i++)
        begin
            if (is_ready(i) && (!found || prio_tbl[i] < prio_tbl[best]))
            begin
                best  = i;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            st = pts_pkg::ST_NONE;
            return;
        end
        if (best != cur_task)
            sw = 1'b1;
        cur_task = best;
    endfunction

    function automatic logic [2:0] post_lock(logic [3:0] lk, inout logic sw);
        logic [2:0] st;
        st = pts_pkg::ST_DONE;
        for (int i = 0; i < n_tasks; i++)
        begin
            if (lock_tbl[i] == lk && (kind_tbl[i] == pts_pkg::EV_TIMED
                                      || kind_tbl[i] == pts_pkg::EV_ENDLESS))
            begin
                kind_tbl[i] = pts_pkg::EV_NONE;
                lock_tbl[i] = 4'd0;
                wake_tbl[i] = '0;
                st = pts_pkg::ST_POSTED;
                reschedule(st, sw);
                return st;
            end
        end
        if (sem_cnt[lk] != 8'hFF)
            sem_cnt[lk]++;
        return st;
    endfunction

    function automatic logic [2:0] wait_lock(logic [3:0] lk, logic [31:0] amt,
                                             inout logic sw);
        logic [2:0] st;
        st = pts_pkg::ST_WAITING;
        if (sem_cnt[lk] != 8'd0)
        begin
            sem_cnt[lk]--;
            return pts_pkg::ST_TAKEN;
        end
        if (!running)
            return pts_pkg::ST_MISUSE;
        kind_tbl[cur_task] = (amt != 0) ? pts_pkg::EV_TIMED : pts_pkg::EV_ENDLESS;
        lock_tbl[cur_task] = lk;
        wake_tbl[cur_task] = ticks + amt;
        reschedule(st, sw);
        return st;
    endfunction

    function automatic pts_pkg::pts_out_t schedule_action(pts_pkg::pts_in_t it);
        pts_pkg::pts_out_t r;
        logic [2:0]        st;
        logic              sw;
        logic              lk_bad;
        st     = pts_pkg::ST_DONE;
        sw     = 1'b0;
        lk_bad = int'(it.lock_id) >= MAX_LOCKS;
        case (it.action)
            pts_pkg::ACT_CREATE:
                if (n_tasks >= MAX_TASKS)
                    st = pts_pkg::ST_FULL;
                else
                begin
                    prio_tbl[n_tasks] = it.task_priority;
                    kind_tbl[n_tasks] = pts_pkg::EV_NONE;
                    lock_tbl[n_tasks] = 4'd0;
                    wake_tbl[n_tasks] = '0;
                    n_tasks++;
                    reschedule(st, sw);
                end
            pts_pkg::ACT_DELAY:
                if (!running)
                    st = pts_pkg::ST_MISUSE;
                else
                begin
                    wake_tbl[cur_task] = ticks + it.amount;
                    kind_tbl[cur_task] = pts_pkg::EV_DELAY;
                    lock_tbl[cur_task] = 4'd0;
                    reschedule(st, sw);
                end
            pts_pkg::ACT_WAIT:
                st = lk_bad ? pts_pkg::ST_MISUSE : wait_lock(it.lock_id, it.amount, sw);
            pts_pkg::ACT_LOCK:
                if (lk_bad || sem_cnt[it.lock_id] > 8'd1)
                    st = pts_pkg::ST_MISUSE;
                else
                    st = wait_lock(it.lock_id, it.amount, sw);
            pts_pkg::ACT_POST:
                st = lk_bad ? pts_pkg::ST_MISUSE : post_lock(it.lock_id, sw);
            pts_pkg::ACT_UNLOCK:
                if (lk_bad || sem_cnt[it.lock_id] != 8'd0)
                    st = pts_pkg::ST_MISUSE;
                else
                    st = post_lock(it.lock_id, sw);
            pts_pkg::ACT_TICK:
            begin
                ticks++;
                reschedule(st, sw);
            end
            pts_pkg::ACT_INIT_LOCK:
                if (lk_bad)
                    st = pts_pkg::ST_MISUSE;
                else
                    sem_cnt[it.lock_id] = it.lock_count;
            pts_pkg::ACT_SET_TICKS:
                ticks = it.amount;
            pts_pkg::ACT_RUN:
            begin
                running = 1'b1;
                reschedule(st, sw);
            end
            pts_pkg::ACT_WAIT_FINISH:
                if (!running)
                    st = pts_pkg::ST_MISUSE;
                else if (kind_tbl[cur_task] == pts_pkg::EV_NONE)
                    st = pts_pkg::ST_TAKEN;
                else
                begin
                    kind_tbl[cur_task] = pts_pkg::EV_NONE;
                    lock_tbl[cur_task] = 4'd0;
                    st = pts_pkg::ST_TIMEOUT;
                end
            default:
                st = pts_pkg::ST_MISUSE;
        endcase
        r.next_task     = cur_task[3:0];
        r.switch_needed = sw;
        r.status        = st;
        r.ticks_now     = ticks;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pts_pkg::pts_out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                prio_tbl[i] = '0;
                kind_tbl[i] = pts_pkg::EV_NONE;
                lock_tbl[i] = '0;
                wake_tbl[i] = '0;
            end
            for (int i = 0; i < MAX_LOCKS; i++)
                sem_cnt[i] = (i == 0) ? 8'd1 : 8'd0;
            n_tasks  = 0;
            cur_task = 0;
            running  = 1'b0;
            ticks    = '0;
            errors   = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected: %h", out_data);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.next_task !== want.next_task)
                    begin
                        $error("next_task expected %0d got %0d",
                               want.next_task, out_data.next_task);
                        errors++;
                    end
                    if (out_data.switch_needed !== want.switch_needed)
                    begin
                        $error("switch_needed expected %0d got %0d",
                               want.switch_needed, out_data.switch_needed);
                        errors++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $error("status expected %0d got %0d",
                               want.status, out_data.status);
                        errors++;
                    end
                    if (out_data.ticks_now !== want.ticks_now)
                    begin
                        $error("ticks_now expected %h got %h",
                               want.ticks_now, out_data.ticks_now);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(schedule_action(in_data));
        end
    end

endmodule

// ===== tb/sv/priority_task_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler_tb
// stimulus and verdict for the task scheduler
// ----------------------------------------------------------------------------
// A directed opening covers misuse before run, semaphore extremes, tick wrap
// and the wait outcomes; random actions with small lock ids and short timeouts
// follow. Both sides idle at random and the receiver holds off once for a long
// stretch so the block backs up.
module priority_task_scheduler_tb;

    localparam int N_RANDOM  = 730;
    localparam int CYC_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    pts_pkg::pts_in_t  in_data;
    logic              out_valid;
    logic              out_stall;
    pts_pkg::pts_out_t out_data;
    int                errors;
    int                pending;
    int                cycles = 0;
    logic              no_gaps;

    priority_task_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    priority_task_scheduler_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("[priority_task_scheduler] ERROR");
            $finish;
        end
    end

    function automatic pts_pkg::pts_in_t mk(logic [3:0] a, logic [7:0] p, logic [3:0] l,
                                            logic [31:0] am, logic [7:0] c);
        pts_pkg::pts_in_t it;
        it.action        = a;
        it.task_priority = p;
        it.lock_id       = l;
        it.amount        = am;
        it.lock_count    = c;
        return it;
    endfunction

    function automatic pts_pkg::pts_in_t random_action();
        pts_pkg::pts_in_t it;
        int               pick;
        it      = mk(pts_pkg::ACT_TICK, 8'($urandom), 4'($urandom_range(0, 3)),
                     32'($urandom_range(0, 6)), 8'($urandom));
        pick    = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            it.lock_id = 4'($urandom);
        if ($urandom_range(0, 19) == 0)
            it.amount = 32'($urandom);
        if (pick < 3)       it.action = pts_pkg::ACT_CREATE;
        else if (pick < 12) it.action = pts_pkg::ACT_DELAY;
        else if (pick < 27) it.action = pts_pkg::ACT_WAIT;
        else if (pick < 39) it.action = pts_pkg::ACT_LOCK;
        else if (pick < 52) it.action = pts_pkg::ACT_POST;
        else if (pick < 62) it.action = pts_pkg::ACT_UNLOCK;
        else if (pick < 80) it.action = pts_pkg::ACT_TICK;
        else if (pick < 84) it.action = pts_pkg::ACT_INIT_LOCK;
        else if (pick < 87)
        begin
            it.action = pts_pkg::ACT_SET_TICKS;
            if ($urandom_range(0, 1) == 1)
                it.amount = 32'hFFFF_FFFF - 32'($urandom_range(0, 4));
        end
        else if (pick < 89) it.action = pts_pkg::ACT_RUN;
        else if (pick < 98) it.action = pts_pkg::ACT_WAIT_FINISH;
        else                it.action = 4'($urandom_range(11, 15));
        if (it.action == pts_pkg::ACT_INIT_LOCK && $urandom_range(0, 1) == 1)
            it.lock_count = 8'($urandom_range(0, 2));
        return it;
    endfunction

    task automatic send(pts_pkg::pts_in_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // receiver: random stall per item, one long hold-off partway through
    initial
    begin
        int n;
        int got;
        got = 0;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = no_gaps ? 0 : $urandom_range(0, 13);
            if (got == 300)
                n = 250;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            got++;
        end
    end

    initial
    begin
        no_gaps  = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // misuse before run, semaphore extremes
        send(mk(pts_pkg::ACT_WAIT_FINISH, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_DELAY, 8'd0, 4'd0, 32'd5, 8'd0));
        send(mk(pts_pkg::ACT_WAIT, 8'd0, 4'd1, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_LOCK, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_UNLOCK, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_INIT_LOCK, 8'hFF, 4'd15, 32'hFFFF_FFFF, 8'hFF));
        send(mk(pts_pkg::ACT_POST, 8'd0, 4'd15, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_LOCK, 8'd0, 4'd15, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_UNLOCK, 8'd0, 4'd15, 32'd0, 8'd0));
        send(mk(4'd11, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(4'd15, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_CREATE, 8'hFF, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_CREATE, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_CREATE, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_RUN, 8'd0, 4'd0, 32'd0, 8'd0));
        // tick wrap, long delay, timed wait woken by post, endless wait
        send(mk(pts_pkg::ACT_SET_TICKS, 8'd0, 4'd0, 32'hFFFF_FFFE, 8'd0));
        send(mk(pts_pkg::ACT_TICK, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_TICK, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_DELAY, 8'd0, 4'd0, 32'hFFFF_FFFF, 8'd0));
        send(mk(pts_pkg::ACT_WAIT, 8'd0, 4'd2, 32'd3, 8'd0));
        send(mk(pts_pkg::ACT_POST, 8'd0, 4'd2, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_WAIT, 8'd0, 4'd3, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_WAIT_FINISH, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_TICK, 8'd0, 4'd0, 32'd0, 8'd0));
        send(mk(pts_pkg::ACT_WAIT_FINISH, 8'd0, 4'd0, 32'd0, 8'd0));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 60 == 59)
                no_gaps = ~no_gaps;
            send(random_action());
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("[priority_task_scheduler] OK");
        else
            $display("[priority_task_scheduler] ERROR");
        $finish;
    end

endmodule
